[hdl/secp256k1_field_multiply_assert.svh]
// Assertion macros used by the field multiplier RTL.
`ifndef SECP256K1_FIELD_MULTIPLY_ASSERT_SVH
`define SECP256K1_FIELD_MULTIPLY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFM_ASSERT_NOW(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define SFM_ASSERT_NEXT(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

[hdl/sfm_pkg.sv]
// ----------------------------------------------------------------------------
// sfm_pkg
// Types and constants for the secp256k1 field multiplier.
// ----------------------------------------------------------------------------
package sfm_pkg;

	localparam int LimbW    = 64;
	localparam int WordW    = 32;
	localparam int NumWords = 8;
	localparam int NumCols  = 2 * NumWords - 1;
	localparam int ColW     = 2 * WordW + 3;
	localparam int ProdW    = 512;
	localparam int FieldW   = 256;
	localparam int FoldW    = FieldW + 34;
	localparam int TopW     = FoldW - FieldW;

	// p = 2^256 - (2^32 + 977); fold constant low part
	localparam logic [9:0] FoldLow = 10'd977;

	typedef logic [LimbW-1:0]     limb_t;
	typedef logic [WordW-1:0]     word_t;
	typedef logic [2*WordW-1:0]   pp_t;
	typedef logic [ColW-1:0]      col_t;
	typedef logic [ProdW-1:0]     prod_t;
	typedef logic [FieldW-1:0]    field_t;
	typedef logic [FoldW-1:0]     fold_t;

	// pipeline control shared by the stage modules
	typedef struct packed {
		logic advance;
	} pipe_ctrl_t;

endpackage

[hdl/sfm_in_if.sv]
// ----------------------------------------------------------------------------
// sfm_in_if
// Operand channel: two 256-bit operands as four limbs each.
// ----------------------------------------------------------------------------
interface sfm_in_if import sfm_pkg::*; ();
	logic  valid;
	logic  ready;
	limb_t a_limb0;
	limb_t a_limb1;
	limb_t a_limb2;
	limb_t a_limb3;
	limb_t b_limb0;
	limb_t b_limb1;
	limb_t b_limb2;
	limb_t b_limb3;

	modport source (output valid, a_limb0, a_limb1, a_limb2, a_limb3,
		b_limb0, b_limb1, b_limb2, b_limb3, input ready);
	modport sink (input valid, a_limb0, a_limb1, a_limb2, a_limb3,
		b_limb0, b_limb1, b_limb2, b_limb3, output ready);
endinterface

[hdl/sfm_out_if.sv]
// ----------------------------------------------------------------------------
// sfm_out_if
// Result channel: reduced product as four limbs.
// ----------------------------------------------------------------------------
interface sfm_out_if import sfm_pkg::*; ();
	logic  valid;
	logic  ready;
	limb_t prod_limb0;
	limb_t prod_limb1;
	limb_t prod_limb2;
	limb_t prod_limb3;

	modport source (output valid, prod_limb0, prod_limb1, prod_limb2, prod_limb3,
		input ready);
	modport sink (input valid, prod_limb0, prod_limb1, prod_limb2, prod_limb3,
		output ready);
endinterface

[hdl/sfm_mul_array.sv]
// ----------------------------------------------------------------------------
// sfm_mul_array
// 256x256 product: 32x32 partial products, column sums, final 512-bit add.
// ----------------------------------------------------------------------------
module sfm_mul_array import sfm_pkg::*; (
	input  logic       clk,
	input  pipe_ctrl_t ctrl,
	input  field_t     a,
	input  field_t     b,
	output prod_t      prod
);

	pp_t   pp_s1 [NumWords][NumWords];
	col_t  col_s2 [NumCols];
	prod_t prod_s3;
	col_t  col_d [NumCols];
	prod_t vec_l, vec_m, vec_h;

	// stage 1: register every 32x32 partial product
	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			for (int i = 0; i < NumWords; i++) begin
				for (int j = 0; j < NumWords; j++) begin
					pp_s1[i][j] <= pp_t'(a[i*WordW +: WordW]) * pp_t'(b[j*WordW +: WordW]);
				end
			end
		end
	end

	// stage 2: sum partial products of equal weight
	always_comb begin
		for (int k = 0; k < NumCols; k++) begin
			col_d[k] = '0;
		end
		for (int i = 0; i < NumWords; i++) begin
			for (int j = 0; j < NumWords; j++) begin
				col_d[i+j] = col_d[i+j] + col_t'(pp_s1[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			col_s2 <= col_d;
		end
	end

	// stage 3: split columns into three non-overlapping vectors and add
	// (the top column holds a single partial product and has no carry bits)
	always_comb begin
		vec_l = '0;
		vec_m = '0;
		vec_h = '0;
		for (int k = 0; k < NumCols; k++) begin
			vec_l[k*WordW +: WordW]     = col_s2[k][WordW-1:0];
			vec_m[(k+1)*WordW +: WordW] = col_s2[k][2*WordW-1:WordW];
		end
		for (int k = 0; k < NumCols - 1; k++) begin
			vec_h[(k+2)*WordW +: 3]     = col_s2[k][ColW-1:2*WordW];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			prod_s3 <= vec_l + vec_m + vec_h;
		end
	end

	assign prod = prod_s3;

endmodule

[hdl/sfm_reduce.sv]
// ----------------------------------------------------------------------------
// sfm_reduce
// Two folds modulo 2^256 - 0x1000003D1, final carry dropped.
// ----------------------------------------------------------------------------
module sfm_reduce import sfm_pkg::*; (
	input  logic       clk,
	input  pipe_ctrl_t ctrl,
	input  prod_t      prod,
	output field_t     result
);

	fold_t  fold_s4;
	field_t result_s5;
	fold_t  hi, lo;
	logic [TopW-1:0] top;
	field_t top_ext, top_k;

	// fold one: lo + hi*2^32 + hi*977, written as shifts
	always_comb begin
		hi = fold_t'(prod[ProdW-1:FieldW]);
		lo = fold_t'(prod[FieldW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			fold_s4 <= lo + (hi << 32) + (hi << 10) + hi - (hi << 5) - (hi << 4);
		end
	end

	// fold two: overflow times the fold constant added into the low 256 bits
	always_comb begin
		top     = fold_s4[FoldW-1:FieldW];
		top_ext = field_t'(top);
		top_k   = (top_ext << 32) + top_ext * field_t'(FoldLow);
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			result_s5 <= fold_s4[FieldW-1:0] + top_k;
		end
	end

	assign result = result_s5;

endmodule

[hdl/secp256k1_field_multiply.sv]
// ----------------------------------------------------------------------------
// secp256k1_field_multiply
// Pipeline: 5 register stages, pp_s1, col_s2, prod_s3, fold_s4 and result_s5;
// each transaction's valid bit moves through valid_q along with its data.
// Throughput: one transaction per cycle; a stalled result parks in an output
// skid register, and the pipeline and the input hold while it is occupied.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`include "secp256k1_field_multiply_assert.svh"

module secp256k1_field_multiply import sfm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	sfm_in_if.sink     in_ch,
	sfm_out_if.source  out_ch
);

	logic [4:0] valid_q;
	logic       skid_valid_q;
	pipe_ctrl_t ctrl;
	field_t     a, b, result;
	field_t     skid_q, out_data;
	prod_t      prod;

	// advance the whole pipe unless a parked result waits
	assign ctrl.advance = !skid_valid_q;
	assign in_ch.ready  = ctrl.advance;

	assign a = {in_ch.a_limb3, in_ch.a_limb2, in_ch.a_limb1, in_ch.a_limb0};
	assign b = {in_ch.b_limb3, in_ch.b_limb2, in_ch.b_limb1, in_ch.b_limb0};

	// shift valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl.advance) begin
			valid_q <= {valid_q[3:0], in_ch.valid};
		end
	end

	// park the result when the sink stalls, release it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ch.ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (valid_q[4] && !out_ch.ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q && valid_q[4] && !out_ch.ready) begin
			skid_q <= result;
		end
	end

	sfm_mul_array u_mul (
		.clk  (clk),
		.ctrl (ctrl),
		.a    (a),
		.b    (b),
		.prod (prod)
	);

	sfm_reduce u_red (
		.clk    (clk),
		.ctrl   (ctrl),
		.prod   (prod),
		.result (result)
	);

	// present the parked result first, it is the older one
	assign out_data          = skid_valid_q ? skid_q : result;
	assign out_ch.valid      = valid_q[4] || skid_valid_q;
	assign out_ch.prod_limb0 = out_data[63:0];
	assign out_ch.prod_limb1 = out_data[127:64];
	assign out_ch.prod_limb2 = out_data[191:128];
	assign out_ch.prod_limb3 = out_data[255:192];

	// check the valid pipeline and the skid register against the stall control
	`SFM_ASSERT_NEXT(a_accept_enters, clk, arst_n, in_ch.valid && in_ch.ready, valid_q[0])
	`SFM_ASSERT_NEXT(a_stall_holds, clk, arst_n, !ctrl.advance, $stable(valid_q))
	`SFM_ASSERT_NEXT(a_shift, clk, arst_n, ctrl.advance, valid_q[4:1] == $past(valid_q[3:0]))
	`SFM_ASSERT_NEXT(a_skid_holds, clk, arst_n, skid_valid_q && !out_ch.ready, skid_valid_q && $stable(skid_q))

endmodule
